// File: hw/rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// Delimiter token splitter package
// Shared constants, register indexes and the cell control type.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int MAX_DELIM_BYTES = 8;

  localparam int FILL_W    = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RESET  = CFG_DATA_W'(44);
  localparam logic [FILL_W-1:0]     DELIM_LENGTH_RESET = FILL_W'(1);

  typedef struct packed {
    logic              shift;
    logic              app;
    logic [FILL_W-1:0] fill;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/dts_if.sv
// ----------------------------------------------------------------------------
// Delimiter token splitter channels
// Valid/ready channels for input bytes, result words and register writes.
// ----------------------------------------------------------------------------
interface dts_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       string_end;

  modport source (output valid, has_byte, data_byte, string_end, input ready);
  modport sink (input valid, has_byte, data_byte, string_end, output ready);
endinterface

interface dts_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       token_done;
  logic       run_last;

  modport source (output valid, byte_valid, out_byte, token_done, run_last,
                  input ready);
  modport sink (input valid, byte_valid, out_byte, token_done, run_last,
                output ready);
endinterface

interface dts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dts_pkg::CFG_IDX_W-1:0]  index;
  logic [dts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/dts_cell.sv
// ----------------------------------------------------------------------------
// Delimiter token splitter window cell
// Holds one window byte, takes its neighbor's byte on a shift, loads a new
// byte at the fill position and compares itself with its delimiter byte.
// ----------------------------------------------------------------------------
module dts_cell #(
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dts_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          nb_i,
  input  logic [7:0]          dlm_i,
  output logic [7:0]          q_o,
  output logic                eq_o
);

  localparam logic [dts_pkg::FILL_W-1:0] POS      = dts_pkg::FILL_W'(IDX);
  localparam logic [dts_pkg::FILL_W-1:0] POS_NEXT = dts_pkg::FILL_W'(IDX + 1);

  logic [7:0] byte_q;
  logic [7:0] byte_d;
  logic       load_here;

  assign load_here = ctrl_i.app && (ctrl_i.fill == POS);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = (ctrl_i.app && (ctrl_i.fill == POS_NEXT)) ? data_i : nb_i;
    end else if (load_here) begin
      byte_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign q_o  = byte_q;
  assign eq_o = load_here ? (data_i == dlm_i) : (byte_q == dlm_i);

endmodule

// File: hw/rtl/delimiter_token_splitter_core.sv
// ----------------------------------------------------------------------------
// Delimiter token splitter core
// Splits a byte stream into tokens at a configured delimiter of 1 to
// MAX_DELIM_BYTES bytes, using a row of window cells.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   in_i     sink       has_byte, data_byte, string_end
//   out_o    source     byte_valid, out_byte, token_done, run_last
//   cfg_i    sink       index, data (0: delimiter bytes, 1: delimiter length)
//
// An input word that causes at most one result is taken every cycle while
// the output is not stalled. A word that causes more results holds the input
// until its last result, one result per cycle through the output register
// while the output is not stalled. A delimiter match that leaves bytes in the
// window (possible only after the length was shortened) also holds the input
// for cell shifting. Reset empties the window and loads ',' with length one.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_core #(
  parameter int MAX_DELIM_BYTES = dts_pkg::MAX_DELIM_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dts_in_if.sink    in_i,
  dts_out_if.source out_o,
  dts_cfg_if.sink   cfg_i
);

  localparam int FW = dts_pkg::FILL_W;
  localparam int N  = MAX_DELIM_BYTES;
  localparam logic [FW-1:0] N_W = FW'(N);

  logic [dts_pkg::CFG_DATA_W-1:0] dlm_q;
  logic [FW-1:0]                  len_q;
  logic [FW-1:0]                  fill_q, fill_d;
  logic [FW-1:0]                  skip_q, skip_d;
  logic                           pend_q, pend_d;
  logic                           end_q, end_d;

  logic       out_valid_q, out_valid_d;
  logic       bv_q, bv_d;
  logic [7:0] ob_q, ob_d;
  logic       td_q, td_d;
  logic       rl_q, rl_d;

  logic [FW-1:0] len_l;
  logic          acc, app, active, out_free;
  logic [FW-1:0] fill_e;
  logic          end_e;
  logic          match_e;
  logic [7:0]    byte0_e;
  logic          shift, emit, e_byte, last;
  logic [FW-1:0] fill_log;

  logic [7:0] cell_q [N];
  logic [7:0] nb     [N];
  logic       eq_e   [N];

  dts_pkg::cell_ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlm_q <= dts_pkg::DELIM_BYTES_RESET;
      len_q <= dts_pkg::DELIM_LENGTH_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dts_pkg::REG_DELIM_BYTES:  dlm_q <= cfg_i.data;
        dts_pkg::REG_DELIM_LENGTH: len_q <= cfg_i.data[FW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (len_q == '0) begin
      len_l = FW'(1);
    end else if (len_q > N_W) begin
      len_l = N_W;
    end else begin
      len_l = len_q;
    end
  end

  assign in_i.ready = !pend_q;
  assign acc        = in_i.valid && !pend_q;
  assign app        = acc && in_i.has_byte;
  assign active     = pend_q || acc;
  assign out_free   = !out_valid_q || out_o.ready;
  assign fill_e     = fill_q + FW'(app);
  assign end_e      = end_q || (acc && in_i.string_end);
  assign byte0_e    = (app && (fill_q == '0)) ? in_i.data_byte : cell_q[0];

  assign ctrl.shift = shift;
  assign ctrl.app   = app;
  assign ctrl.fill  = fill_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_last
      assign nb[i] = '0;
    end else begin : g_mid
      assign nb[i] = cell_q[i+1];
    end

    dts_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .data_i (in_i.data_byte),
      .nb_i   (nb[i]),
      .dlm_i  (dlm_q[8*i +: 8]),
      .q_o    (cell_q[i]),
      .eq_o   (eq_e[i])
    );
  end

  always_comb begin
    match_e = 1'b1;
    for (int i = 0; i < N; i++) begin
      match_e = match_e && (eq_e[i] || (FW'(i) >= len_l));
    end
  end

  always_comb begin
    fill_d = fill_q;
    skip_d = skip_q;
    end_d  = end_q;
    shift  = 1'b0;
    emit   = 1'b0;
    e_byte = 1'b0;
    if (skip_q != '0) begin
      shift  = 1'b1;
      fill_d = fill_q - FW'(1);
      skip_d = skip_q - FW'(1);
    end else if (active) begin
      fill_d = fill_e;
      end_d  = end_e;
      if (out_free) begin
        if (fill_e >= len_l) begin
          emit = 1'b1;
          if (match_e) begin
            if (fill_e == len_l) begin
              fill_d = '0;
            end else begin
              shift  = 1'b1;
              fill_d = fill_e - FW'(1);
              skip_d = len_l - FW'(1);
            end
          end else begin
            e_byte = 1'b1;
            shift  = 1'b1;
            fill_d = fill_e - FW'(1);
          end
        end else if (end_e) begin
          emit = 1'b1;
          if (fill_e != '0) begin
            e_byte = 1'b1;
            shift  = 1'b1;
            fill_d = fill_e - FW'(1);
          end else begin
            end_d = 1'b0;
          end
        end
      end
    end
  end

  assign fill_log = fill_d - skip_d;
  assign last     = !((fill_log >= len_l) || end_d);
  assign pend_d   = active && ((skip_d != '0) || (fill_d >= len_l) || end_d);

  always_comb begin
    out_valid_d = out_valid_q;
    bv_d        = bv_q;
    ob_d        = ob_q;
    td_d        = td_q;
    rl_d        = rl_q;
    if (emit) begin
      out_valid_d = 1'b1;
      bv_d        = e_byte;
      ob_d        = e_byte ? byte0_e : 8'd0;
      td_d        = !e_byte;
      rl_d        = last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      skip_q      <= '0;
      pend_q      <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      skip_q      <= skip_d;
      pend_q      <= pend_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bv_q <= bv_d;
    ob_q <= ob_d;
    td_q <= td_d;
    rl_q <= rl_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.byte_valid = bv_q;
  assign out_o.out_byte   = ob_q;
  assign out_o.token_done = td_q;
  assign out_o.run_last   = rl_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= N_W)
    else $error("window fill exceeds the number of cells");

  a_skip_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != '0) |-> (pend_q && (fill_q > skip_q)))
    else $error("cell shifting outside a pending word");

  a_end_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_q |-> pend_q)
    else $error("string end held without pending work");

  a_more_results : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !last) |=> pend_q)
    else $error("word released before its last result");

  a_last_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last && (skip_d == '0)) |=> !pend_q)
    else $error("input held after the last result of a word");

endmodule
